@@ rtl/dsmg_pkg.sv @@
// ----------------------------------------------------------------------------
// dsmg_pkg
// Shared types and constants of the disc stamp max grid: operation codes,
// register indexes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package dsmg_pkg;

    localparam int POS_W  = 32;
    localparam int EXT_W  = 31;
    localparam int RAD_W  = 31;
    localparam int LVL_W  = 8;
    localparam int OP_W   = 2;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    typedef enum logic [OP_W-1:0] {
        OP_STAMP = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1,
        REG_EXTENT_X = 2'd2,
        REG_EXTENT_Y = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_X = 2'd0,
        DIV_Y = 2'd1,
        DIV_R = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        SQ_R = 2'd0,
        SQ_X = 2'd1,
        SQ_Y = 2'd2
    } sq_sel_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DIVX,
        S_DIVXW,
        S_DIVY,
        S_DIVYW,
        S_DIVR,
        S_DIVRW,
        S_BOUNDS,
        S_CHECK,
        S_SQR,
        S_SQRW,
        S_SQX,
        S_SQXW,
        S_SQY,
        S_SQYW,
        S_INIT,
        S_READ,
        S_WRITE,
        S_QREAD,
        S_LOAD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        div_sel_t div_sel;
        logic     bounds_load;
        logic     sq_start;
        sq_sel_t  sq_sel;
        logic     scan_init;
        logic     cell_read;
        logic     cell_update;
        logic     query_read;
        logic     clr_step;
        logic     result_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic div_done;
        logic sq_done;
        logic range_empty;
        logic in_area;
        logic scan_last;
        logic clr_last;
    } sts_t;

endpackage

@@ rtl/dsmg_chan_if.sv @@
// ----------------------------------------------------------------------------
// dsmg channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface dsmg_req_if;
    import dsmg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [RAD_W-1:0]         radius;
    logic [LVL_W-1:0]         level;

    modport source (
        output valid, operation, pos_x, pos_y, radius, level,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, radius, level,
        output ready
    );
endinterface

interface dsmg_rsp_if;
    import dsmg_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] trample_level;
    logic             inside_area;

    modport source (
        output valid, trample_level, inside_area,
        input  ready
    );
    modport sink (
        input  valid, trample_level, inside_area,
        output ready
    );
endinterface

@@ rtl/dsmg_div.sv @@
// ----------------------------------------------------------------------------
// dsmg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsmg_div #(
    parameter int DW = 41,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic          rem_nz
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;

    // trial subtract of the next partial remainder
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // iteration step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

@@ rtl/dsmg_sqr.sv @@
// ----------------------------------------------------------------------------
// dsmg_sqr
// Shift-and-add squarer, one operand bit per cycle.
// ----------------------------------------------------------------------------
module dsmg_sqr #(
    parameter int MW = 41
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MW-1:0]   operand,
    output logic            done,
    output logic [2*MW-1:0] square
);
    localparam int CNT_W = $clog2(MW + 1);

    logic [2*MW-1:0]  mcand_reg, mcand_next;
    logic [MW-1:0]    mplier_reg, mplier_next;
    logic [2*MW-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // accumulate one partial product per cycle
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = (2*MW)'(operand);
            mplier_next = operand;
            acc_next    = '0;
            cnt_next    = CNT_W'(MW);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[2*MW-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MW-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done   = done_reg;
    assign square = acc_reg;

endmodule

@@ rtl/dsmg_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsmg_ctrl
// Sequencer: clearing sweep, cell mapping, disc scan, query and result.
// ----------------------------------------------------------------------------
module dsmg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  dsmg_pkg::sts_t    sts,
    output dsmg_pkg::cmd_t    cmd,
    output logic              in_ready,
    output logic              out_valid
);
    import dsmg_pkg::*;

    state_t state_reg, state_next;
    logic   item_reg, item_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            item_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
        end
    end

    // item in flight flag, tells a clear item from the reset sweep
    always_comb
    begin
        item_next = item_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            item_next = 1'b1;
        end
        else if (state_reg == S_RESULT && out_ready)
        begin
            item_next = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = item_reg ? S_LOAD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_STAMP: state_next = S_DIVX;
                    OP_QUERY: state_next = S_DIVX;
                    OP_CLEAR: state_next = S_CLEAR;
                    OP_NOP:   state_next = S_LOAD;
                endcase
            end
            S_DIVX:  state_next = S_DIVXW;
            S_DIVXW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:  state_next = S_DIVYW;
            S_DIVYW:
            begin
                if (sts.div_done)
                begin
                    if (sts.op == OP_QUERY)
                    begin
                        state_next = sts.in_area ? S_QREAD : S_LOAD;
                    end
                    else
                    begin
                        state_next = S_DIVR;
                    end
                end
            end
            S_DIVR:  state_next = S_DIVRW;
            S_DIVRW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_BOUNDS;
                end
            end
            S_BOUNDS: state_next = S_CHECK;
            S_CHECK:  state_next = sts.range_empty ? S_LOAD : S_SQR;
            S_SQR:    state_next = S_SQRW;
            S_SQRW:
            begin
                if (sts.sq_done)
                begin
                    state_next = S_SQX;
                end
            end
            S_SQX:    state_next = S_SQXW;
            S_SQXW:
            begin
                if (sts.sq_done)
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:    state_next = S_SQYW;
            S_SQYW:
            begin
                if (sts.sq_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:   state_next = S_READ;
            S_READ:   state_next = S_WRITE;
            S_WRITE:  state_next = sts.scan_last ? S_LOAD : S_READ;
            S_QREAD:  state_next = S_LOAD;
            S_LOAD:   state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd       = '0;
        cmd.div_sel = DIV_X;
        cmd.sq_sel  = SQ_R;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_DISPATCH: cmd.div_sel = DIV_X;
            S_DIVX:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_X;
            end
            S_DIVXW:    cmd.div_sel = DIV_X;
            S_DIVY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_Y;
            end
            S_DIVYW:    cmd.div_sel = DIV_Y;
            S_DIVR:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_R;
            end
            S_DIVRW:    cmd.div_sel = DIV_R;
            S_BOUNDS:   cmd.bounds_load = 1'b1;
            S_CHECK:    cmd.sq_sel = SQ_R;
            S_SQR:
            begin
                cmd.sq_start = 1'b1;
                cmd.sq_sel   = SQ_R;
            end
            S_SQRW:     cmd.sq_sel = SQ_R;
            S_SQX:
            begin
                cmd.sq_start = 1'b1;
                cmd.sq_sel   = SQ_X;
            end
            S_SQXW:     cmd.sq_sel = SQ_X;
            S_SQY:
            begin
                cmd.sq_start = 1'b1;
                cmd.sq_sel   = SQ_Y;
            end
            S_SQYW:     cmd.sq_sel = SQ_Y;
            S_INIT:     cmd.scan_init = 1'b1;
            S_READ:     cmd.cell_read = 1'b1;
            S_WRITE:    cmd.cell_update = 1'b1;
            S_QREAD:    cmd.query_read = 1'b1;
            S_LOAD:     cmd.result_load = 1'b1;
            S_RESULT:   out_valid = 1'b1;
            default:    cmd.div_sel = DIV_X;
        endcase
    end

endmodule

@@ rtl/dsmg_datapath.sv @@
// ----------------------------------------------------------------------------
// dsmg_datapath
// Area registers, item registers, cell mapping, disc scan arithmetic and
// the level grid memory.
// ----------------------------------------------------------------------------
module dsmg_datapath #(
    parameter int GRID_SIZE = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dsmg_pkg::cmd_t                    cmd,
    output dsmg_pkg::sts_t                    sts,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsmg_pkg::APB_AW-1:0]       paddr,
    input  logic [dsmg_pkg::APB_DW-1:0]       pwdata,
    output logic [dsmg_pkg::APB_DW-1:0]       prdata,
    input  logic [dsmg_pkg::OP_W-1:0]         operation,
    input  logic signed [dsmg_pkg::POS_W-1:0] pos_x,
    input  logic signed [dsmg_pkg::POS_W-1:0] pos_y,
    input  logic [dsmg_pkg::RAD_W-1:0]        radius,
    input  logic [dsmg_pkg::LVL_W-1:0]        level,
    output logic [dsmg_pkg::LVL_W-1:0]        trample_level,
    output logic                              inside_area
);
    import dsmg_pkg::*;

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int NW    = $clog2(GRID_SIZE + 1);
    localparam int NUMW  = POS_W + 2 + NW;
    localparam int QW    = NUMW + 1;
    localparam int SW    = QW + 2;
    localparam int MW    = NUMW;
    localparam int DXW   = MW + 1;
    localparam int SQW   = 2 * MW + 2;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [NUMW-1:0] N_S     = NUMW'(GRID_SIZE);
    localparam logic signed [SW-1:0]   NMAX_S  = SW'(GRID_SIZE - 1);
    localparam logic signed [QW-1:0]   NMAX_Q  = QW'(GRID_SIZE - 1);
    localparam logic [CW-1:0]          NMAX_C  = CW'(GRID_SIZE - 1);

    // area registers
    logic signed [POS_W-1:0] centre_x_reg, centre_y_reg;
    logic [EXT_W-1:0]        extent_x_reg, extent_y_reg;
    logic [EXT_W-1:0]        ex_eff, ey_eff;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;

    // item registers
    op_t                     op_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [LVL_W-1:0]        level_reg;

    // mapping
    logic signed [POS_W-1:0] sel_pos, sel_ctr;
    logic [EXT_W-1:0]        sel_ext;
    logic signed [POS_W:0]   diff33;
    logic signed [POS_W+1:0] num34;
    logic signed [NUMW-1:0]  numn;
    logic [NUMW-1:0]         num_mag, rad_num, div_dividend;
    logic                    div_neg_reg;
    logic                    div_done, div_rem_nz;
    logic [NUMW-1:0]         div_quot;
    logic signed [QW-1:0]    q_plain, q_up, cell_val;
    logic signed [QW-1:0]    cx_reg, cy_reg;
    logic [NUMW-1:0]         reach_reg;

    // bounds
    logic signed [SW-1:0]    reach_s, cx_s, cy_s;
    logic signed [SW-1:0]    lox, hix, loy, hiy;
    logic [CW-1:0]           xlo_c, xhi_c, ylo_c, yhi_c;
    logic signed [SW-1:0]    xlo_s, ylo_s, dxlo_s, dylo_s;
    logic                    empty_c;
    logic [CW-1:0]           xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [DXW-1:0]   dx0_reg, dy0_reg;
    logic                    empty_reg;

    // squares and scan
    logic [MW-1:0]           sq_operand;
    logic                    sq_done;
    logic [2*MW-1:0]         sq_square;
    logic signed [SQW-1:0]   r2_reg, dxsq_reg, dysq_reg;
    logic signed [SQW-1:0]   rowsq_reg, sumsq_reg, rowsq_step;
    logic signed [SQW-1:0]   dx_w, dy_w;
    logic [CW-1:0]           x_reg, y_reg;
    logic signed [DXW-1:0]   dx_reg, dy_reg;
    logic                    hit;

    // query
    logic signed [POS_W:0]   qdx, qdy;
    logic [POS_W:0]          qmx, qmy;
    logic                    inside_c;
    logic [CW-1:0]           qx, qy;

    // memory
    logic [LVL_W-1:0]        mem [DEPTH];
    logic [LVL_W-1:0]        rdata_reg;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr, scan_addr, q_addr;
    logic [LVL_W-1:0]        mem_wdata;
    logic [AW-1:0]           clr_cnt_reg;
    logic                    clr_last;

    // result registers
    logic [LVL_W-1:0]        trample_reg;
    logic                    inside_reg;

    // register writes and reads
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            extent_x_reg <= EXT_W'(32000);
            extent_y_reg <= EXT_W'(32000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CENTRE_X: centre_x_reg <= pwdata;
                REG_CENTRE_Y: centre_y_reg <= pwdata;
                REG_EXTENT_X: extent_x_reg <= pwdata[EXT_W-1:0];
                REG_EXTENT_Y: extent_y_reg <= pwdata[EXT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CENTRE_X: prdata = centre_x_reg;
            REG_CENTRE_Y: prdata = centre_y_reg;
            REG_EXTENT_X: prdata = {1'b0, extent_x_reg};
            REG_EXTENT_Y: prdata = {1'b0, extent_y_reg};
        endcase
    end

    // zero extent acts as one
    assign ex_eff = (extent_x_reg == '0) ? EXT_W'(1) : extent_x_reg;
    assign ey_eff = (extent_y_reg == '0) ? EXT_W'(1) : extent_y_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= op_t'(operation);
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            radius_reg <= radius;
            level_reg  <= level;
        end
    end

    // divider operands: shifted position times grid size, or radius times size
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_Y:
            begin
                sel_pos = py_reg;
                sel_ctr = centre_y_reg;
                sel_ext = ey_eff;
            end
            default:
            begin
                sel_pos = px_reg;
                sel_ctr = centre_x_reg;
                sel_ext = ex_eff;
            end
        endcase
    end

    assign diff33  = {sel_pos[POS_W-1], sel_pos} - {sel_ctr[POS_W-1], sel_ctr};
    assign num34   = {diff33[POS_W], diff33} + (POS_W+2)'(sel_ext);
    assign numn    = NUMW'(num34) * N_S;
    assign num_mag = numn[NUMW-1] ? NUMW'(-numn) : NUMW'(numn);
    assign rad_num = NUMW'(radius_reg) * NUMW'(GRID_SIZE);
    assign div_dividend = (cmd.div_sel == DIV_R) ? rad_num : num_mag;

    dsmg_div #(
        .DW (NUMW),
        .VW (EXT_W + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  ({sel_ext, 1'b0}),
        .done     (div_done),
        .quotient (div_quot),
        .rem_nz   (div_rem_nz)
    );

    // floor for negative numerators, ceiling for the reach
    assign q_plain  = QW'(div_quot);
    assign q_up     = q_plain + QW'(div_rem_nz);
    assign cell_val = div_neg_reg ? -q_up : q_plain;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_neg_reg <= (cmd.div_sel != DIV_R) && numn[NUMW-1];
        end
        if (div_done)
        begin
            unique case (cmd.div_sel)
                DIV_X:   cx_reg <= cell_val;
                DIV_Y:   cy_reg <= cell_val;
                default: reach_reg <= q_up[NUMW-1:0];
            endcase
        end
    end

    // scan window clipped to the grid
    assign reach_s = SW'(reach_reg);
    assign cx_s    = SW'(cx_reg);
    assign cy_s    = SW'(cy_reg);
    assign lox     = cx_s - reach_s;
    assign hix     = cx_s + reach_s;
    assign loy     = cy_s - reach_s;
    assign hiy     = cy_s + reach_s;
    assign empty_c = (hix < 0) || (lox > NMAX_S) || (hiy < 0) || (loy > NMAX_S);
    assign xlo_c   = (lox < 0) ? '0 : lox[CW-1:0];
    assign ylo_c   = (loy < 0) ? '0 : loy[CW-1:0];
    assign xhi_c   = (hix > NMAX_S) ? NMAX_C : hix[CW-1:0];
    assign yhi_c   = (hiy > NMAX_S) ? NMAX_C : hiy[CW-1:0];
    assign xlo_s   = SW'(xlo_c);
    assign ylo_s   = SW'(ylo_c);
    assign dxlo_s  = xlo_s - cx_s;
    assign dylo_s  = ylo_s - cy_s;

    always_ff @(posedge clk)
    begin
        if (cmd.bounds_load)
        begin
            xlo_reg   <= xlo_c;
            xhi_reg   <= xhi_c;
            ylo_reg   <= ylo_c;
            yhi_reg   <= yhi_c;
            dx0_reg   <= dxlo_s[DXW-1:0];
            dy0_reg   <= dylo_s[DXW-1:0];
            empty_reg <= empty_c;
        end
    end

    // squares of reach and of the first offsets
    always_comb
    begin
        unique case (cmd.sq_sel)
            SQ_X:    sq_operand = dx0_reg[DXW-1] ? MW'(-dx0_reg) : MW'(dx0_reg);
            SQ_Y:    sq_operand = dy0_reg[DXW-1] ? MW'(-dy0_reg) : MW'(dy0_reg);
            default: sq_operand = reach_reg;
        endcase
    end

    dsmg_sqr #(
        .MW (MW)
    ) u_sqr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .square  (sq_square)
    );

    // running distance, advanced by 2d+1 per step
    assign dx_w       = SQW'(dx_reg);
    assign dy_w       = SQW'(dy_reg);
    assign rowsq_step = rowsq_reg + (dy_w <<< 1) + SQW'(1);
    assign hit        = sumsq_reg <= r2_reg;

    always_ff @(posedge clk)
    begin
        if (sq_done)
        begin
            unique case (cmd.sq_sel)
                SQ_X:    dxsq_reg <= SQW'(sq_square);
                SQ_Y:    dysq_reg <= SQW'(sq_square);
                default: r2_reg   <= SQW'(sq_square);
            endcase
        end
        if (cmd.scan_init)
        begin
            rowsq_reg <= dxsq_reg + dysq_reg;
            sumsq_reg <= dxsq_reg + dysq_reg;
            x_reg     <= xlo_reg;
            y_reg     <= ylo_reg;
            dx_reg    <= dx0_reg;
            dy_reg    <= dy0_reg;
        end
        else if (cmd.cell_update)
        begin
            if (x_reg == xhi_reg)
            begin
                rowsq_reg <= rowsq_step;
                sumsq_reg <= rowsq_step;
                x_reg     <= xlo_reg;
                dx_reg    <= dx0_reg;
                y_reg     <= y_reg + 1'b1;
                dy_reg    <= dy_reg + 1'b1;
            end
            else
            begin
                sumsq_reg <= sumsq_reg + (dx_w <<< 1) + SQW'(1);
                x_reg     <= x_reg + 1'b1;
                dx_reg    <= dx_reg + 1'b1;
            end
        end
    end

    // query window test and clamped cell
    assign qdx      = {px_reg[POS_W-1], px_reg} - {centre_x_reg[POS_W-1], centre_x_reg};
    assign qdy      = {py_reg[POS_W-1], py_reg} - {centre_y_reg[POS_W-1], centre_y_reg};
    assign qmx      = qdx[POS_W] ? (POS_W+1)'(-qdx) : (POS_W+1)'(qdx);
    assign qmy      = qdy[POS_W] ? (POS_W+1)'(-qdy) : (POS_W+1)'(qdy);
    assign inside_c = (qmx <= (POS_W+1)'(ex_eff)) && (qmy <= (POS_W+1)'(ey_eff));
    assign qx       = (cx_reg < 0) ? '0 : ((cx_reg > NMAX_Q) ? NMAX_C : cx_reg[CW-1:0]);
    assign qy       = (cy_reg < 0) ? '0 : ((cy_reg > NMAX_Q) ? NMAX_C : cy_reg[CW-1:0]);

    // grid memory, row-major
    assign scan_addr = AW'(y_reg) * AW'(GRID_SIZE) + AW'(x_reg);
    assign q_addr    = AW'(qy) * AW'(GRID_SIZE) + AW'(qx);
    assign clr_last  = clr_cnt_reg == AW'(DEPTH - 1);
    assign mem_we    = cmd.clr_step || (cmd.cell_update && hit && (rdata_reg < level_reg));
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : scan_addr;
    assign mem_wdata = cmd.clr_step ? '0 : level_reg;
    assign mem_re    = cmd.cell_read || cmd.query_read;
    assign mem_raddr = cmd.query_read ? q_addr : scan_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            trample_reg <= (op_reg == OP_QUERY && inside_c) ? rdata_reg : '0;
            inside_reg  <= (op_reg == OP_QUERY) && inside_c;
        end
    end

    assign trample_level = trample_reg;
    assign inside_area   = inside_reg;

    // status to the sequencer
    assign sts.op          = op_reg;
    assign sts.div_done    = div_done;
    assign sts.sq_done     = sq_done;
    assign sts.range_empty = empty_reg;
    assign sts.in_area     = inside_c;
    assign sts.scan_last   = (x_reg == xhi_reg) && (y_reg == yhi_reg);
    assign sts.clr_last    = clr_last;

endmodule

@@ rtl/disc_stamp_max_grid_top.sv @@
// ----------------------------------------------------------------------------
// disc_stamp_max_grid_top
// Grid of 8-bit levels over a world area, raised by disc stamps, read by
// position queries and zeroed by clear items.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item (operation, pos_x, pos_y, radius, level); rsp returns
//   exactly one result item per request (trample_level, inside_area).
//   The APB port sets centre and half extents; the user must write them only
//   while no item is in flight, the block itself does not enforce it.
//   One item is worked on at a time; req.ready is high only when idle.
//   Each cell mapping and the reach take one division (NUMW = 34 + bits of
//   GRID_SIZE, 41 at the default size), the divider iterating one quotient
//   bit per cycle. Query: two divisions, then a memory read if the position
//   lies inside the area.
//   Stamp: three divisions and, unless the clipped window is empty, three
//   squarings on the shift-add squarer, then for each cell of the window a
//   read, then a compare and write.
//   Clear: one cell written per cycle over all GRID_SIZE*GRID_SIZE cells.
//   After reset the same sweep runs before req.ready first rises. The
//   result is held in a register and stays valid until rsp.ready; the block
//   waits there while the receiver stalls.
// ----------------------------------------------------------------------------
module disc_stamp_max_grid_top #(
    parameter int GRID_SIZE = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dsmg_req_if.sink                         req,
    dsmg_rsp_if.source                       rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dsmg_pkg::APB_AW-1:0]      paddr,
    input  logic [dsmg_pkg::APB_DW-1:0]      pwdata,
    output logic [dsmg_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import dsmg_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_valid;

    // sequencer
    dsmg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    // arithmetic, registers and grid memory
    dsmg_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .operation     (req.operation),
        .pos_x         (req.pos_x),
        .pos_y         (req.pos_y),
        .radius        (req.radius),
        .level         (req.level),
        .trample_level (rsp.trample_level),
        .inside_area   (rsp.inside_area)
    );

    // handshakes
    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign pready    = 1'b1;

endmodule
